FILE: rtl/rtd_pkg.sv
// Shared constants, breakpoint ROM, types and state encodings for the RTD converter.
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int POINTS      = 58;
  localparam int IDX_W       = $clog2(POINTS);
  localparam int R_W         = 16;
  localparam int T_W         = 10;
  localparam int S_W         = 2;
  // Segment widths stay at or below 40 ohms, so 10*(r-r0) stays below 512.
  localparam int DEN_W       = 6;
  localparam int NUM_W       = 9;
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_C      = 10;
  localparam int TEMP_FIRST  = -70;

  localparam logic signed [T_W-1:0] TEMP_UNDER = T_W'(TEMP_FIRST - 1);
  localparam logic signed [T_W-1:0] TEMP_OVER  = T_W'(TEMP_FIRST + STEP_C * (POINTS - 1) + 1);

  localparam logic [R_W-1:0] OHM_ROM [POINTS] = '{
    16'd723,  16'd763,  16'd803,  16'd842,  16'd882,  16'd921,  16'd960,  16'd1000,
    16'd1039, 16'd1077, 16'd1116, 16'd1155, 16'd1194, 16'd1232, 16'd1270, 16'd1309,
    16'd1347, 16'd1385, 16'd1422, 16'd1460, 16'd1498, 16'd1535, 16'd1573, 16'd1610,
    16'd1647, 16'd1684, 16'd1721, 16'd1758, 16'd1795, 16'd1831, 16'd1868, 16'd1904,
    16'd1941, 16'd1977, 16'd2013, 16'd2049, 16'd2084, 16'd2120, 16'd2156, 16'd2191,
    16'd2226, 16'd2262, 16'd2297, 16'd2332, 16'd2367, 16'd2401, 16'd2436, 16'd2470,
    16'd2505, 16'd2539, 16'd2573, 16'd2607, 16'd2641, 16'd2675, 16'd2709, 16'd2742,
    16'd2776, 16'd2809
  };

  typedef enum logic [S_W-1:0] {
    RANGE_INSIDE = 2'd0,
    RANGE_UNDER  = 2'd1,
    RANGE_OVER   = 2'd2
  } range_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FIX,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [R_W-1:0]   r;
    logic [IDX_W-1:0] seg;
    range_status_t    status;
  } rtd_item_t;

  // Breakpoint temperatures are evenly spaced.
  function automatic logic signed [T_W-1:0] temp_at(input logic [IDX_W-1:0] idx);
    return T_W'(TEMP_FIRST + STEP_C * int'(idx));
  endfunction

endpackage

FILE: rtl/rtd_ifs.sv
// Valid/ready channel interfaces for resistance input and temperature result.
`timescale 1ns / 1ps

interface rtd_in_if;
  import rtd_pkg::*;
  logic           valid;
  logic           ready;
  logic [R_W-1:0] resistance_ohms;

  modport source (output valid, output resistance_ohms, input ready);
  modport sink   (input valid, input resistance_ohms, output ready);
endinterface

interface rtd_out_if;
  import rtd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [T_W-1:0] temperature_c;
  logic [S_W-1:0]        range_status;

  modport source (output valid, output temperature_c, output range_status, input ready);
  modport sink   (input valid, input temperature_c, input range_status, output ready);
endinterface

FILE: rtl/rtd_resistance_to_temperature_unit.sv
// Top level of the PT1000 resistance-to-temperature converter.
//
//  channel   direction  payload                                   handshake
//  in_chan   sink       resistance_ohms[15:0]                     valid & ready
//  out_chan  source     temperature_c[9:0] (signed), range_status valid & ready
//
// The front end takes a transaction, classifies it and runs a binary segment search
// over the breakpoint ROM, one step a cycle, then pushes the item to the queue;
// out-of-range values skip the search.
// The back end runs a 9-step restoring divider plus load, fix and output states;
// it takes no new item until its result is accepted; out-of-range items skip the divide.
// A 2-entry queue lets the front take new transactions while a result is stalled.
// Reset clears control state only; no clearing pass is needed.
`timescale 1ns / 1ps

module rtd_resistance_to_temperature_unit #(
  parameter int QUEUE_DEPTH = rtd_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  rtd_in_if.sink    in_chan,
  rtd_out_if.source out_chan
);
  import rtd_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  rtd_item_t push_item, pop_item;

  rtd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  rtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  rtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

FILE: rtl/rtd_front.sv
// Front end: accepts a resistance, classifies its range and binary-searches the segment.
`timescale 1ns / 1ps

module rtd_front (
  input  logic               clk,
  input  logic               rst_n,
  rtd_in_if.sink             in_chan,
  output logic               push_valid,
  output rtd_pkg::rtd_item_t push_item,
  input  logic               push_ready
);
  import rtd_pkg::*;

  front_state_t     state_r, state_nxt;
  logic [R_W-1:0]   r_r, r_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  range_status_t    status_r, status_nxt;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    status_nxt    = status_r;
    in_chan.ready = 1'b0;
    push_valid    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          r_nxt  = in_chan.resistance_ohms;
          lo_nxt = IDX_W'(1);
          hi_nxt = IDX_W'(POINTS - 1);
          if (in_chan.resistance_ohms < OHM_ROM[0]) begin
            status_nxt = RANGE_UNDER;
            state_nxt  = F_PUSH;
          end else if (in_chan.resistance_ohms > OHM_ROM[POINTS-1]) begin
            status_nxt = RANGE_OVER;
            state_nxt  = F_PUSH;
          end else begin
            status_nxt = RANGE_INSIDE;
            state_nxt  = F_SEARCH;
          end
        end
      end
      F_SEARCH: begin
        // Narrow to the first breakpoint at or above r, searching from index 1.
        if (lo_r == hi_r) begin
          state_nxt = F_PUSH;
        end else if (r_r <= OHM_ROM[mid]) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + 1'b1;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_item = '{r: r_r, seg: lo_r, status: status_r};

endmodule

FILE: rtl/rtd_queue.sv
// Small FIFO that decouples the segment search from the divider.
`timescale 1ns / 1ps

module rtd_queue #(
  parameter int DEPTH = rtd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  rtd_pkg::rtd_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output rtd_pkg::rtd_item_t pop_item,
  input  logic               pop_ready
);
  import rtd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rtd_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/rtd_back.sv
// Back end: serial divide of the segment slope and output register.
`timescale 1ns / 1ps

module rtd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  rtd_pkg::rtd_item_t pop_item,
  output logic               pop_ready,
  rtd_out_if.source          out_chan
);
  import rtd_pkg::*;

  back_state_t           state_r, state_nxt;
  logic signed [T_W-1:0] t0_r, t0_nxt;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic [DEN_W-1:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [T_W-1:0] result_r, result_nxt;
  range_status_t         status_r, status_nxt;

  logic [IDX_W-1:0] seg_lo;
  logic [R_W-1:0]   r0, r1, r_diff, seg_w;
  logic [DEN_W-1:0] diff;
  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   rem_shift;
  logic             rnd;

  assign seg_lo    = pop_item.seg - 1'b1;
  assign r0        = OHM_ROM[seg_lo];
  assign r1        = OHM_ROM[pop_item.seg];
  assign r_diff    = pop_item.r - r0;
  assign seg_w     = r1 - r0;
  assign diff      = r_diff[DEN_W-1:0];
  // 10*diff as shift-and-add
  assign num       = NUM_W'({diff, 3'b000}) + NUM_W'({diff, 1'b0});
  assign rem_shift = {rem_r, quo_r[NUM_W-1]};
  // Negative segment start: round the quotient up so the sum truncates toward zero.
  assign rnd       = t0_r[T_W-1] && (rem_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t0_r     <= t0_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    result_r <= result_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    t0_nxt         = t0_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    result_nxt     = result_r;
    status_nxt     = status_r;
    pop_ready      = 1'b0;
    out_chan.valid = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          status_nxt = pop_item.status;
          t0_nxt     = temp_at(seg_lo);
          den_nxt    = seg_w[DEN_W-1:0];
          quo_nxt    = num;
          rem_nxt    = '0;
          cnt_nxt    = '0;
          unique case (pop_item.status)
            RANGE_UNDER: begin
              result_nxt = TEMP_UNDER;
              state_nxt  = B_DONE;
            end
            RANGE_OVER: begin
              result_nxt = TEMP_OVER;
              state_nxt  = B_DONE;
            end
            default: state_nxt = B_DIV;
          endcase
        end
      end
      B_DIV: begin
        // One restoring step per cycle, quotient bits shift in behind the dividend.
        if (rem_shift >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_shift - {1'b0, den_r});
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[DEN_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = B_FIX;
        end
      end
      B_FIX: begin
        result_nxt = t0_r + T_W'(quo_r) + T_W'(rnd);
        state_nxt  = B_DONE;
      end
      B_DONE: begin
        out_chan.valid = 1'b1;
        if (out_chan.ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_chan.temperature_c = result_r;
  assign out_chan.range_status  = status_r;

endmodule
